// File: src/pcost_pkg.sv
// Package for the plane cost accumulator: shared types, constants and
// register codes. No dependencies.
package pcost_pkg;

    localparam int SCALES_DEF       = 4;
    localparam int WEIGHT_GAMMA_DEF = 14;

    localparam int CLR_W    = 18;   // truncated color cost, Q.8
    localparam int GRD_W    = 17;   // truncated gradient cost, Q.8
    localparam int SAD_W    = 10;   // Lab SAD, also weight table index
    localparam int PIX_W    = 27;   // blended pixel cost, Q.16
    localparam int WGT_W    = 16;
    localparam int ACC_W    = 48;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int WROM_N   = 1024;

    typedef enum logic [2:0] {
        REG_BLEND_ALPHA  = 3'd0,
        REG_TAU_COLOR    = 3'd1,
        REG_TAU_GRADIENT = 3'd2,
        REG_SCALE_W0     = 3'd3,
        REG_SCALE_W1     = 3'd4,
        REG_SCALE_W2     = 3'd5,
        REG_SCALE_W3     = 3'd6,
        REG_NONE         = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [8:0]            blend_alpha;
        logic [9:0]            tau_color;
        logic [8:0]            tau_gradient;
        logic [3:0][WGT_W-1:0] scale_weight;
    } pcost_cfg_t;

    typedef struct packed {
        logic [CLR_W-1:0] clr;
        logic [GRD_W-1:0] grd;
        logic [SAD_W-1:0] sad;
        logic [1:0]       scale_index;
        logic             last;
    } pcost_item_t;

endpackage

// File: src/pcost_if.sv
// Channel interfaces of the plane cost accumulator: input beat and result beat.
// Depends on pcost_pkg.
interface pcost_in_if
    import pcost_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [23:0]       center_lab;
    logic [23:0]       support_lab;
    logic [23:0]       ref_color;
    logic [23:0]       floor_color;
    logic [23:0]       ceil_color;
    logic signed [8:0] ref_gradient;
    logic signed [8:0] floor_gradient;
    logic signed [8:0] ceil_gradient;
    logic [8:0]        floor_fraction;
    logic              out_of_range;
    logic [1:0]        scale_index;
    logic              last;

    modport source (output valid, center_lab, support_lab, ref_color, floor_color,
                    ceil_color, ref_gradient, floor_gradient, ceil_gradient,
                    floor_fraction, out_of_range, scale_index, last, input ready);
    modport sink (input valid, center_lab, support_lab, ref_color, floor_color,
                  ceil_color, ref_gradient, floor_gradient, ceil_gradient,
                  floor_fraction, out_of_range, scale_index, last, output ready);
endinterface

interface pcost_out_if
    import pcost_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACC_W-1:0] plane_cost;

    modport source (output valid, plane_cost, input ready);
    modport sink (input valid, plane_cost, output ready);
endinterface

// File: src/pcost_front.sv
// Front end: accept an input beat, compute Lab SAD and truncated color and
// gradient costs, push the classified item to the queue. Depends on pcost_pkg.
module pcost_front
    import pcost_pkg::*;
(
    pcost_in_if.sink    in_ch,
    input  pcost_cfg_t  cfg,
    input  logic        q_full,
    output logic        q_push,
    output pcost_item_t q_item
);

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // |256*q - f*a - (256-f)*b| for one color channel
    function automatic logic [16:0] chan_cost(input logic [7:0] q, input logic [7:0] a,
                                              input logic [7:0] b, input logic [8:0] f);
        logic [16:0]       pa;
        logic [16:0]       pb;
        logic signed [18:0] d;
        pa = 17'(f * a);
        pb = 17'((9'd256 - f) * b);
        d  = $signed({3'b0, q, 8'b0}) - $signed({2'b0, pa}) - $signed({2'b0, pb});
        return d[18] ? 17'(-d) : 17'(d);
    endfunction

    logic [8:0]         frac;
    logic [SAD_W-1:0]   sad;
    logic [CLR_W-1:0]   clr_raw;
    logic [CLR_W-1:0]   tc;
    logic [GRD_W-1:0]   tg;
    logic signed [19:0] gr20;
    logic signed [19:0] gf20;
    logic signed [19:0] gc20;
    logic signed [19:0] f20;
    logic signed [19:0] gd;
    logic [GRD_W-1:0]   grd_raw;

    always_comb
    begin
        frac = (in_ch.floor_fraction > 9'd256) ? 9'd256 : in_ch.floor_fraction;
        sad  = SAD_W'(absdiff8(in_ch.center_lab[7:0],   in_ch.support_lab[7:0]))
             + SAD_W'(absdiff8(in_ch.center_lab[15:8],  in_ch.support_lab[15:8]))
             + SAD_W'(absdiff8(in_ch.center_lab[23:16], in_ch.support_lab[23:16]));
        clr_raw = CLR_W'(chan_cost(in_ch.ref_color[7:0], in_ch.floor_color[7:0],
                                   in_ch.ceil_color[7:0], frac))
                + CLR_W'(chan_cost(in_ch.ref_color[15:8], in_ch.floor_color[15:8],
                                   in_ch.ceil_color[15:8], frac))
                + CLR_W'(chan_cost(in_ch.ref_color[23:16], in_ch.floor_color[23:16],
                                   in_ch.ceil_color[23:16], frac));
        gr20 = in_ch.ref_gradient;
        gf20 = in_ch.floor_gradient;
        gc20 = in_ch.ceil_gradient;
        f20  = $signed({11'b0, frac});
        gd   = (gr20 <<< 8) - f20 * gf20 - ($signed(20'd256) - f20) * gc20;
        grd_raw = gd[19] ? GRD_W'(-gd) : GRD_W'(gd);
        tc = {cfg.tau_color, 8'b0};
        tg = {cfg.tau_gradient, 8'b0};

        q_item.sad         = sad;
        q_item.scale_index = in_ch.scale_index;
        q_item.last        = in_ch.last;
        // out of range takes both costs at their limits
        if (in_ch.out_of_range)
        begin
            q_item.clr = tc;
            q_item.grd = tg;
        end
        else
        begin
            q_item.clr = (clr_raw > tc) ? tc : clr_raw;
            q_item.grd = (grd_raw > tg) ? tg : grd_raw;
        end
    end

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

endmodule

// File: src/pcost_queue.sv
// Short item queue between front and back end.
// Depends on pcost_pkg.
module pcost_queue
    import pcost_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pcost_item_t push_item,
    input  logic        pop,
    output pcost_item_t head_item,
    output logic        full,
    output logic        empty
);

    pcost_item_t       store_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

// File: src/pcost_back.sv
// Back end: weight lookup, blend, scale multiply, saturating accumulate and
// result register. Depends on pcost_pkg.
module pcost_back
    import pcost_pkg::*;
#(
    parameter int SCALES       = SCALES_DEF,
    parameter int WEIGHT_GAMMA = WEIGHT_GAMMA_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pcost_cfg_t  cfg,
    input  pcost_item_t head_item,
    input  logic        q_empty,
    output logic        q_pop,
    pcost_out_if.source out_ch
);

    typedef logic [WROM_N-1:0][WGT_W-1:0] wtab_t;

    localparam logic [63:0] Gam = (WEIGHT_GAMMA < 1) ? 64'd1 : 64'(WEIGHT_GAMMA);

    // Taylor terms of exp(-1/gamma) scaled by 2^56; past k = 18 they are zero
    localparam logic [63:0] Term0  = 64'd1 << 56;
    localparam logic [63:0] Term1  = Term0  / (Gam * 64'd1);
    localparam logic [63:0] Term2  = Term1  / (Gam * 64'd2);
    localparam logic [63:0] Term3  = Term2  / (Gam * 64'd3);
    localparam logic [63:0] Term4  = Term3  / (Gam * 64'd4);
    localparam logic [63:0] Term5  = Term4  / (Gam * 64'd5);
    localparam logic [63:0] Term6  = Term5  / (Gam * 64'd6);
    localparam logic [63:0] Term7  = Term6  / (Gam * 64'd7);
    localparam logic [63:0] Term8  = Term7  / (Gam * 64'd8);
    localparam logic [63:0] Term9  = Term8  / (Gam * 64'd9);
    localparam logic [63:0] Term10 = Term9  / (Gam * 64'd10);
    localparam logic [63:0] Term11 = Term10 / (Gam * 64'd11);
    localparam logic [63:0] Term12 = Term11 / (Gam * 64'd12);
    localparam logic [63:0] Term13 = Term12 / (Gam * 64'd13);
    localparam logic [63:0] Term14 = Term13 / (Gam * 64'd14);
    localparam logic [63:0] Term15 = Term14 / (Gam * 64'd15);
    localparam logic [63:0] Term16 = Term15 / (Gam * 64'd16);
    localparam logic [63:0] Term17 = Term16 / (Gam * 64'd17);
    localparam logic [63:0] Term18 = Term17 / (Gam * 64'd18);
    localparam logic [63:0] EvenSum = Term0 + Term2 + Term4 + Term6 + Term8 + Term10
                                    + Term12 + Term14 + Term16 + Term18;
    localparam logic [63:0] OddSum  = Term1 + Term3 + Term5 + Term7 + Term9 + Term11
                                    + Term13 + Term15 + Term17;
    localparam logic [63:0] RawRatio = (EvenSum - OddSum + (64'd1 << 23)) >> 24;
    localparam logic [63:0] Ratio    = (RawRatio > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF
                                                                 : RawRatio;

    // exp(-i/gamma) in Q0.16
    function automatic wtab_t build_weights();
        wtab_t       tab;
        logic [63:0] v;
        logic [63:0] e;
        v = 64'd1 << 32;
        for (int i = 0; i < WROM_N; i++)
        begin
            e = (v + 64'h8000) >> 16;
            tab[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
            v = (v * Ratio) >> 32;
        end
        return tab;
    endfunction

    localparam wtab_t WeightRom = build_weights();

    logic                    en;
    logic [8:0]              alpha;
    logic [ACC_W:0]          sum;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    last1_reg, last2_reg, last3_reg, last4_reg;
    logic [CLR_W-1:0]        clr1_reg;
    logic [GRD_W-1:0]        grd1_reg;
    logic [1:0]              sidx1_reg;
    logic [WGT_W-1:0]        w1_reg, w2_reg;
    logic [PIX_W-1:0]        pix2_reg;
    logic [WGT_W-1:0]        sw2_reg, sw3_reg;
    logic [PIX_W+WGT_W-1:0]  pw3_reg;
    logic [PIX_W-1:0]        contrib4_reg;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]        out_cost_reg;

    // whole pipeline holds while a result waits
    assign en    = !out_valid_reg || out_ch.ready;
    assign q_pop = en && !q_empty;
    assign alpha = (cfg.blend_alpha > 9'd256) ? 9'd256 : cfg.blend_alpha;

    always_comb
    begin
        sum      = {1'b0, acc_reg} + (ACC_W+1)'(contrib4_reg);
        acc_next = acc_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (en && v4_reg)
        begin
            acc_next = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
            if (last4_reg)
            begin
                acc_next       = '0;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v1_reg <= !q_empty;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: table read
            w1_reg    <= WeightRom[head_item.sad];
            clr1_reg  <= head_item.clr;
            grd1_reg  <= head_item.grd;
            sidx1_reg <= head_item.scale_index;
            last1_reg <= head_item.last;
            // stage 2: blend, pick scale weight
            pix2_reg  <= PIX_W'(alpha * clr1_reg) + PIX_W'((9'd256 - alpha) * grd1_reg);
            sw2_reg   <= (32'(sidx1_reg) < 32'(SCALES)) ? cfg.scale_weight[sidx1_reg] : '0;
            w2_reg    <= w1_reg;
            last2_reg <= last1_reg;
            // stage 3: support weight
            pw3_reg   <= pix2_reg * w2_reg;
            sw3_reg   <= sw2_reg;
            last3_reg <= last2_reg;
            // stage 4: scale weight at full product width, back to Q.16
            contrib4_reg <= PIX_W'(((PIX_W+2*WGT_W)'(pw3_reg) * sw3_reg) >> 32);
            last4_reg    <= last3_reg;
        end
        if (en && v4_reg && last4_reg)
        begin
            out_cost_reg <= acc_next == '0 ? (sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0])
                                            : acc_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.plane_cost = out_cost_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
                     (en && v4_reg && last4_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after last beat");
    assert property (@(posedge clk) disable iff (!rst_n)
                     !en |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg}))
        else $error("pipeline moved while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
                     $rose(out_valid_reg) |-> $past(v4_reg && last4_reg && en))
        else $error("result without a last beat");

endmodule

// File: src/cross_scale_plane_cost_accumulator.sv
// Top level of the plane cost accumulator: APB register file, front end,
// item queue and back end. Depends on pcost_pkg and the channel interfaces.
//
// One input beat is one support-window pixel. The block sustains one beat per
// clock while no result waits: the front end computes the Lab SAD and the
// truncated, interpolated color and gradient costs in the accept cycle and
// pushes the item into a four-entry queue; the back end pops one item per
// cycle while not held, through four stages (weight table read, alpha blend,
// support weight multiply, scale weight multiply) and then adds into a 48-bit
// saturating accumulator. The result beat carrying plane_cost waits in an
// output register, loaded when the last beat leaves stage 4; while it is not
// taken the back end holds and the queue absorbs up to four more input beats.
// The weight table is a 1024-entry ROM built at elaboration from WEIGHT_GAMMA,
// read once per unheld cycle into a register. Write registers only while idle.
module cross_scale_plane_cost_accumulator
    import pcost_pkg::*;
#(
    parameter int SCALES       = SCALES_DEF,
    parameter int WEIGHT_GAMMA = WEIGHT_GAMMA_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    pcost_in_if.sink          in_ch,
    pcost_out_if.source       out_ch
);

    pcost_cfg_t  cfg_reg, cfg_next;
    reg_idx_t    reg_sel;
    logic        wr_en;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    pcost_item_t push_item;
    pcost_item_t head_item;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    // register writes; unknown index is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_BLEND_ALPHA:  cfg_next.blend_alpha     = pwdata[8:0];
                REG_TAU_COLOR:    cfg_next.tau_color       = pwdata[9:0];
                REG_TAU_GRADIENT: cfg_next.tau_gradient    = pwdata[8:0];
                REG_SCALE_W0:     cfg_next.scale_weight[0] = pwdata[15:0];
                REG_SCALE_W1:     cfg_next.scale_weight[1] = pwdata[15:0];
                REG_SCALE_W2:     cfg_next.scale_weight[2] = pwdata[15:0];
                REG_SCALE_W3:     cfg_next.scale_weight[3] = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_BLEND_ALPHA:  prdata = DATA_W'(cfg_reg.blend_alpha);
            REG_TAU_COLOR:    prdata = DATA_W'(cfg_reg.tau_color);
            REG_TAU_GRADIENT: prdata = DATA_W'(cfg_reg.tau_gradient);
            REG_SCALE_W0:     prdata = DATA_W'(cfg_reg.scale_weight[0]);
            REG_SCALE_W1:     prdata = DATA_W'(cfg_reg.scale_weight[1]);
            REG_SCALE_W2:     prdata = DATA_W'(cfg_reg.scale_weight[2]);
            REG_SCALE_W3:     prdata = DATA_W'(cfg_reg.scale_weight[3]);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_alpha     <= 9'd230;
            cfg_reg.tau_color       <= 10'd10;
            cfg_reg.tau_gradient    <= 9'd2;
            cfg_reg.scale_weight[0] <= 16'd16384;
            cfg_reg.scale_weight[1] <= 16'd16384;
            cfg_reg.scale_weight[2] <= 16'd16384;
            cfg_reg.scale_weight[3] <= 16'd16384;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pcost_front u_front (
        .in_ch  (in_ch),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    pcost_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    pcost_back #(
        .SCALES       (SCALES),
        .WEIGHT_GAMMA (WEIGHT_GAMMA)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head_item (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

endmodule

// File: tb/tb_cross_scale_plane_cost_accumulator.sv
// Self-checking bench for the plane cost accumulator: drives pixel beats and
// APB register writes, predicts each plane cost and checks every result beat.
// Depends on pcost_pkg, the channel interfaces and the block itself.

class plane_cost_scoreboard;
    logic [47:0] acc_sum;
    logic [47:0] cost_q[$];
    int          errors;

    function new();
        acc_sum = '0;
        errors  = 0;
    endfunction

    // Fold one accepted pixel beat into the running sum; queue a total on last.
    function void note_pixel(logic [47:0] contrib, bit last);
        logic [48:0] s;
        s = {1'b0, acc_sum} + {1'b0, contrib};
        acc_sum = s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
        if (last)
        begin
            cost_q.push_back(acc_sum);
            acc_sum = '0;
        end
    endfunction

    function void check_cost(logic [47:0] got, realtime t);
        logic [47:0] exp_cost;
        if (cost_q.size() == 0)
        begin
            $display("%0t: unexpected plane_cost beat, actual %0d", t, got);
            errors++;
            return;
        end
        exp_cost = cost_q.pop_front();
        if (got !== exp_cost)
        begin
            $display("%0t: plane_cost mismatch, expected %0d actual %0d", t, exp_cost, got);
            errors++;
        end
    endfunction
endclass

module tb_cross_scale_plane_cost_accumulator;
    import pcost_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 550;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pcost_in_if  in_ch();
    pcost_out_if out_ch();

    cross_scale_plane_cost_accumulator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    plane_cost_scoreboard sb;

    // Local copy of the configuration and the support weight table.
    logic [8:0]  cfg_alpha;
    logic [9:0]  cfg_tau_color;
    logic [8:0]  cfg_tau_grad;
    logic [15:0] cfg_scale_w[4];
    logic [15:0] exp_weight[WROM_N];

    int  idle_cycles;
    bit  hold_off;      // long receiver stall requested by the stimulus

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Build exp(-i/gamma) in Q0.16 by the same integer recurrence as the block.
    task automatic build_weights();
        logic [63:0] term, even_s, odd_s, r, v, e, g;
        g = WEIGHT_GAMMA_DEF;
        term = 64'd1 << 56;
        even_s = term;
        odd_s = 0;
        for (int k = 1; k < 40 && term != 0; k++)
        begin
            term = term / (g * k);
            if (k % 2) odd_s += term; else even_s += term;
        end
        r = (even_s - odd_s + (64'd1 << 23)) >> 24;
        if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
        v = 64'd1 << 32;
        for (int i = 0; i < WROM_N; i++)
        begin
            e = (v + 64'h8000) >> 16;
            exp_weight[i] = (e > 65535) ? 16'hFFFF : e[15:0];
            v = (v * r) >> 32;
        end
    endtask

    // Predict the 48-bit contribution of one pixel beat.
    function automatic logic [47:0] pixel_contrib(
        logic [23:0] clab, logic [23:0] slab, logic [23:0] rc, logic [23:0] fc,
        logic [23:0] cc, logic signed [8:0] gr, logic signed [8:0] gf,
        logic signed [8:0] gc, logic [8:0] frac, bit oor, logic [1:0] sidx);
        longint alpha, f, tc, tg, sad, clr, grd, d, pix;
        logic [127:0] prod;
        alpha = (cfg_alpha > 256) ? 256 : cfg_alpha;
        f = (frac > 256) ? 256 : frac;
        tc = longint'(cfg_tau_color) << 8;
        tg = longint'(cfg_tau_grad) << 8;
        sad = 0;
        clr = 0;
        for (int c = 0; c < 3; c++)
        begin
            longint a, b;
            a = clab[8*c +: 8];
            b = slab[8*c +: 8];
            sad += (a > b) ? a - b : b - a;
            d = 256 * longint'(rc[8*c +: 8]) - f * longint'(fc[8*c +: 8])
                - (256 - f) * longint'(cc[8*c +: 8]);
            clr += (d < 0) ? -d : d;
        end
        d = 256 * longint'(gr) - f * longint'(gf) - (256 - f) * longint'(gc);
        grd = (d < 0) ? -d : d;
        if (oor)
            pix = alpha * tc + (256 - alpha) * tg;
        else
        begin
            if (clr > tc) clr = tc;
            if (grd > tg) grd = tg;
            pix = alpha * clr + (256 - alpha) * grd;
        end
        prod = 128'(pix) * exp_weight[sad & 1023] * cfg_scale_w[sidx];
        return prod[79:32];
    endfunction

    // APB write: setup then access; mirror the register locally.
    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BLEND_ALPHA:  cfg_alpha = value[8:0];
            REG_TAU_COLOR:    cfg_tau_color = value[9:0];
            REG_TAU_GRADIENT: cfg_tau_grad = value[8:0];
            REG_SCALE_W0:     cfg_scale_w[0] = value[15:0];
            REG_SCALE_W1:     cfg_scale_w[1] = value[15:0];
            REG_SCALE_W2:     cfg_scale_w[2] = value[15:0];
            REG_SCALE_W3:     cfg_scale_w[3] = value[15:0];
            default: ;
        endcase
    endtask

    task automatic write_config(int a, int tcl, int tgr, int w0, int w1, int w2, int w3);
        reg_write(REG_BLEND_ALPHA, a);
        reg_write(REG_TAU_COLOR, tcl);
        reg_write(REG_TAU_GRADIENT, tgr);
        reg_write(REG_SCALE_W0, w0);
        reg_write(REG_SCALE_W1, w1);
        reg_write(REG_SCALE_W2, w2);
        reg_write(REG_SCALE_W3, w3);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one pixel beat; hold it until accepted, then note it.
    task automatic send_pixel(logic [23:0] clab, logic [23:0] slab, logic [23:0] rc,
        logic [23:0] fc, logic [23:0] cc, logic [8:0] gr, logic [8:0] gf,
        logic [8:0] gc, logic [8:0] frac, bit oor, logic [1:0] sidx, bit last);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.center_lab     <= clab;
        in_ch.support_lab    <= slab;
        in_ch.ref_color      <= rc;
        in_ch.floor_color    <= fc;
        in_ch.ceil_color     <= cc;
        in_ch.ref_gradient   <= gr;
        in_ch.floor_gradient <= gf;
        in_ch.ceil_gradient  <= gc;
        in_ch.floor_fraction <= frac;
        in_ch.out_of_range   <= oor;
        in_ch.scale_index    <= sidx;
        in_ch.last           <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_pixel(pixel_contrib(clab, slab, rc, fc, cc, gr, gf, gc, frac, oor, sidx),
                      last);
    endtask

    // Random pixel; colors often close so costs land around the tau limits.
    task automatic send_random(bit last);
        logic [23:0] rc, fc, cc, clab;
        logic [8:0]  gr;
        int          mode;
        mode = $urandom_range(0, 3);
        clab = 24'($urandom);
        rc = 24'($urandom);
        if (mode == 0)
        begin
            fc = rc ^ 24'($urandom_range(0, 7));
            cc = rc ^ 24'($urandom_range(0, 7));
        end
        else
        begin
            fc = 24'($urandom);
            cc = 24'($urandom);
        end
        gr = 9'($signed($urandom_range(0, 510)) - 255);
        send_pixel(clab,
                   (mode == 1) ? clab ^ 24'($urandom_range(0, 15)) : 24'($urandom),
                   rc, fc, cc, gr,
                   (mode == 0) ? gr : 9'($urandom),
                   (mode == 0) ? gr : 9'($urandom),
                   9'($urandom_range(0, 511)),
                   ($urandom_range(0, 9) == 0), 2'($urandom), last);
    endtask

    // Drop valid, then wait until every expected total has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.cost_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = gap_len();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_cost(out_ch.plane_cost, $realtime);
        end
    end

    // Watchdog: count cycles with no accepted beat on either channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int plen;
        sb = new();
        build_weights();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.center_lab = '0;
        in_ch.support_lab = '0;
        in_ch.ref_color = '0;
        in_ch.floor_color = '0;
        in_ch.ceil_color = '0;
        in_ch.ref_gradient = '0;
        in_ch.floor_gradient = '0;
        in_ch.ceil_gradient = '0;
        in_ch.floor_fraction = '0;
        in_ch.out_of_range = 1'b0;
        in_ch.scale_index = '0;
        in_ch.last = 1'b0;
        cfg_alpha = 230;
        cfg_tau_color = 10;
        cfg_tau_grad = 2;
        foreach (cfg_scale_w[i]) cfg_scale_w[i] = 16384;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes, out of range, every scale.
        send_pixel(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 9'h0, 9'h0, 9'h0, 9'd1, 0, 0, 1);
        send_pixel(24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h0, 24'hFFFFFF, 9'd255, -9'sd255,
                   9'd255, 9'd256, 0, 1, 0);
        send_pixel(24'h0, 24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h0, -9'sd255, 9'd255,
                   -9'sd255, 9'd511, 0, 2, 0);
        send_pixel(24'h123456, 24'h123456, 24'h808080, 24'h7F7F7F, 24'h818181,
                   9'd10, 9'd9, 9'd11, 9'd128, 1, 3, 1);
        wait_drained();

        // Extremes of the settings; out-of-range pixels with max weight
        // give the largest per-pixel contribution.
        write_config(511, 1023, 511, 65535, 65535, 65535, 65535);
        for (int i = 0; i < 8; i++)
            send_pixel(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 9'h0, 9'h0, 9'h0,
                       9'd256, 1, 2'(i), i == 7);
        wait_drained();
        write_config(0, 0, 0, 0, 1, 32768, 65535);
        for (int i = 0; i < 4; i++)
            send_pixel(24'hFF00FF, 24'h00FF00, 24'hFFFFFF, 24'h0, 24'h0,
                       9'd255, -9'sd255, 9'd0, 9'd300, 1'(i & 1), 2'(i), i == 3);
        wait_drained();
        write_config(256, 765, 510, 40000, 20000, 65535, 1000);
        wait_drained();

        // Random phases: long hold-off in the first, new settings between.
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 0) hold_off = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS / 5; n += plen)
            begin
                plen = $urandom_range(1, 12);
                for (int k = 0; k < plen; k++) send_random(k == plen - 1);
            end
            wait_drained();
            write_config($urandom_range(0, 511), $urandom_range(0, 1023),
                         $urandom_range(0, 511), $urandom, $urandom, $urandom, $urandom);
        end

        wait_drained();
        if (sb.errors == 0 && sb.cost_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
